/* rtl/sbt_pkg.sv */
// Constants and register codes for the subcarrier baseline tracker.
// No dependencies; imported by subcarrier_baseline_tracker.
package sbt_pkg;

  localparam int NUM_SC    = 64;
  localparam int SC_W      = 6;
  localparam int SC_IDX_W  = $clog2(NUM_SC);
  localparam int AMP_W     = 16;
  localparam int DEV_W     = AMP_W + 1;
  localparam int ALPHA_W   = 16;
  localparam int KLOG_W    = 4;
  localparam int KLOG_MAX  = 10;
  localparam int SUM_W     = AMP_W + KLOG_MAX;
  localparam int FR_W      = KLOG_MAX + 1;
  localparam int ESUM_W    = AMP_W + SC_IDX_W;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_CALIB_LOG2 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_EMA_ALPHA  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TRACK_EN   = REG_IDX_W'(2);

  localparam logic [KLOG_W-1:0]  CALIB_LOG2_RST = KLOG_W'(7);
  localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST  = ALPHA_W'(655);
  localparam logic [AMP_W-1:0]   AMP_MAX        = '1;

endpackage

/* rtl/subcarrier_baseline_tracker.sv */
// Subcarrier baseline tracker: calibration sums, baselines with EMA tracking,
// per-frame mean absolute deviation. Depends on sbt_pkg.
// Pipeline: input stage, then result register.
// Throughput: one item per cycle while out_ready holds; the sum and baseline read-modify-write is
// forwarded between back-to-back items on one subcarrier.
// Reset: synchronous; restores register defaults, clears readiness, frame count and
// energy sum. Memories are not cleared; the first calibration frame writes each sum it carries.
module subcarrier_baseline_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbt_pkg::PADDR_W-1:0]       paddr,
  input  logic [sbt_pkg::DATA_W-1:0]        pwdata,
  output logic [sbt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sbt_pkg::AMP_W-1:0]         amplitude,
  input  logic [sbt_pkg::SC_W-1:0]          subcarrier,
  input  logic                              frame_end,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sbt_pkg::DEV_W-1:0]  deviation,
  output logic                              is_ready,
  output logic [sbt_pkg::AMP_W-1:0]         motion_energy,
  output logic                              energy_valid,
  output logic                              calibration_done,
  output logic                              frame_last
);
  import sbt_pkg::*;

  localparam int PROD_W = DEV_W + ALPHA_W + 1;
  localparam int NB_W   = AMP_W + 3;
  localparam logic [SC_W:0] NumScL = (SC_W + 1)'(NUM_SC);

  logic [KLOG_W-1:0]  calib_frames_log2;
  logic [ALPHA_W-1:0] ema_alpha;
  logic               tracking_enable;

  logic [SUM_W-1:0] cal_mem  [NUM_SC];
  logic [AMP_W-1:0] base_mem [NUM_SC];
  logic [SUM_W-1:0] cal_rd;
  logic [AMP_W-1:0] base_rd;
  logic             cal_hit;
  logic             base_hit;
  logic [SUM_W-1:0] cal_byp;
  logic [AMP_W-1:0] base_byp;

  logic [NUM_SC-1:0] tracked;
  logic [NUM_SC-1:0] tracked_next;
  logic [KLOG_W-1:0] k_done;
  logic [KLOG_W-1:0] k_done_next;
  logic [FR_W-1:0]   frames_seen;
  logic [FR_W-1:0]   frames_seen_next;
  logic              ready_flag;
  logic              ready_flag_next;
  logic [ESUM_W-1:0] energy_sum;
  logic [ESUM_W-1:0] energy_sum_next;

  logic              s1_valid;
  logic [AMP_W-1:0]  s1_amp;
  logic [SC_W-1:0]   s1_sc;
  logic              s1_fend;
  logic              s1_restart;
  logic              s1_adv;
  logic              in_accept;
  logic [SC_IDX_W-1:0] s1_idx;
  logic [SC_IDX_W-1:0] in_idx;

  logic                     sc_ok;
  logic                     ready_cur;
  logic [FR_W-1:0]          frames_cur;
  logic [ESUM_W-1:0]        esum_cur;
  logic [SUM_W-1:0]         cal_cur;
  logic [SUM_W-1:0]         cal_shift;
  logic [AMP_W-1:0]         base_cur;
  logic signed [DEV_W-1:0]  dev;
  logic [AMP_W-1:0]         mag;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] prod_sh;
  logic [NB_W-1:0]          delta;
  logic signed [NB_W-1:0]   nb;
  logic [AMP_W-1:0]         base_new;
  logic [SUM_W-1:0]         cal_new;
  logic [ESUM_W:0]          esum_add;
  logic [ESUM_W-1:0]        esum_sat;
  logic [ESUM_W-1:0]        energy_full;
  logic [KLOG_W-1:0]        k_eff;
  logic [FR_W-1:0]          frames_inc;
  logic                     cal_wr;
  logic                     base_wr;
  logic signed [DEV_W-1:0]  dev_o;
  logic                     rdy_o;
  logic [AMP_W-1:0]         energy_o;
  logic                     evalid_o;
  logic                     done_o;

  assign pready    = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign s1_idx    = s1_sc[SC_IDX_W-1:0];
  assign in_idx    = subcarrier[SC_IDX_W-1:0];

  always_comb begin
    prdata = '0;
    case (paddr[PADDR_W-1:2])
      REG_CALIB_LOG2: prdata = DATA_W'(calib_frames_log2);
      REG_EMA_ALPHA:  prdata = DATA_W'(ema_alpha);
      REG_TRACK_EN:   prdata = DATA_W'(tracking_enable);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_frames_log2 <= CALIB_LOG2_RST;
      ema_alpha         <= EMA_ALPHA_RST;
      tracking_enable   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[PADDR_W-1:2])
        REG_CALIB_LOG2: calib_frames_log2 <= pwdata[KLOG_W-1:0];
        REG_EMA_ALPHA:  ema_alpha         <= pwdata[ALPHA_W-1:0];
        REG_TRACK_EN:   tracking_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sc_ok      = {1'b0, s1_sc} < NumScL;
    ready_cur  = s1_restart ? 1'b0 : ready_flag;
    frames_cur = s1_restart ? '0 : frames_seen;
    esum_cur   = s1_restart ? '0 : energy_sum;
    k_eff      = (calib_frames_log2 > KLOG_W'(KLOG_MAX)) ? KLOG_W'(KLOG_MAX)
                                                          : calib_frames_log2;
    cal_cur    = cal_hit ? cal_byp : cal_rd;
    cal_shift  = cal_cur >> k_done;
    base_cur   = tracked[s1_idx] ? (base_hit ? base_byp : base_rd)
                                 : cal_shift[AMP_W-1:0];
    dev        = $signed({1'b0, s1_amp}) - $signed({1'b0, base_cur});
    mag        = dev[DEV_W-1] ? AMP_W'(-dev) : AMP_W'(dev);
    prod       = dev * $signed({1'b0, ema_alpha});
    prod_rnd   = prod + $signed(PROD_W'(32768));
    prod_sh    = prod_rnd >>> ALPHA_W;
    delta      = prod_sh[NB_W-1:0];
    nb         = $signed({3'b000, base_cur}) + $signed(delta);
    if (nb[NB_W-1]) begin
      base_new = '0;
    end else if (nb[NB_W-2:AMP_W] != '0) begin
      base_new = AMP_MAX;
    end else begin
      base_new = nb[AMP_W-1:0];
    end
    cal_new  = (frames_cur == '0) ? SUM_W'(s1_amp) : cal_cur + SUM_W'(s1_amp);
    esum_add = {1'b0, esum_cur} + (ESUM_W + 1)'(mag);
    esum_sat = esum_add[ESUM_W] ? '1 : esum_add[ESUM_W-1:0];
    frames_inc = frames_cur + FR_W'(1);

    ready_flag_next  = ready_cur;
    frames_seen_next = frames_cur;
    energy_sum_next  = esum_cur;
    tracked_next     = tracked;
    k_done_next      = k_done;
    cal_wr           = 1'b0;
    base_wr          = 1'b0;
    dev_o            = '0;
    rdy_o            = 1'b0;
    energy_o         = '0;
    energy_full      = '0;
    evalid_o         = 1'b0;
    done_o           = 1'b0;

    if (ready_cur) begin
      if (sc_ok) begin
        dev_o           = dev;
        rdy_o           = 1'b1;
        energy_sum_next = esum_sat;
        if (tracking_enable) begin
          base_wr              = 1'b1;
          tracked_next[s1_idx] = 1'b1;
        end
      end
      if (s1_fend) begin
        energy_full     = energy_sum_next >> SC_IDX_W;
        energy_o        = (energy_full > ESUM_W'(AMP_MAX)) ? AMP_MAX
                                                            : energy_full[AMP_W-1:0];
        evalid_o        = 1'b1;
        energy_sum_next = '0;
      end
    end else begin
      cal_wr = sc_ok;
      if (s1_fend) begin
        energy_sum_next  = '0;
        frames_seen_next = frames_inc;
        if (frames_inc >= (FR_W'(1) << k_eff)) begin
          ready_flag_next = 1'b1;
          done_o          = 1'b1;
          tracked_next    = '0;
          k_done_next     = k_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && cal_wr) begin
      cal_mem[s1_idx] <= cal_new;
    end
    if (s1_adv && base_wr) begin
      base_mem[s1_idx] <= base_new;
    end
    if (in_accept) begin
      cal_rd   <= cal_mem[in_idx];
      base_rd  <= base_mem[in_idx];
      cal_byp  <= cal_new;
      base_byp <= base_new;
      s1_amp     <= amplitude;
      s1_sc      <= subcarrier;
      s1_fend    <= frame_end;
      s1_restart <= restart;
    end
    if (s1_adv) begin
      deviation        <= dev_o;
      is_ready         <= rdy_o;
      motion_energy    <= energy_o;
      energy_valid     <= evalid_o;
      calibration_done <= done_o;
      frame_last       <= s1_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      cal_hit     <= 1'b0;
      base_hit    <= 1'b0;
      ready_flag  <= 1'b0;
      frames_seen <= '0;
      energy_sum  <= '0;
      tracked     <= '0;
      k_done      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        cal_hit  <= s1_adv && cal_wr && (s1_sc == subcarrier);
        base_hit <= s1_adv && base_wr && (s1_sc == subcarrier);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid   <= 1'b1;
        ready_flag  <= ready_flag_next;
        frames_seen <= frames_seen_next;
        energy_sum  <= energy_sum_next;
        tracked     <= tracked_next;
        k_done      <= k_done_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibration_done |-> !is_ready && !energy_valid)
    else $error("calibration_done with is_ready or energy_valid");

  a_dev_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_ready |-> deviation == '0)
    else $error("nonzero deviation while not ready");

  a_energy_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && energy_valid |-> frame_last)
    else $error("energy_valid off frame end");

  a_energy_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !energy_valid |-> motion_energy == '0)
    else $error("motion_energy without energy_valid");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_sc) && $stable(s1_amp))
    else $error("stalled item lost");

endmodule

/* tb/subcarrier_baseline_tracker_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for subcarrier_baseline_tracker: random idling on both
// streams, APB register writes between phases, results checked against a predictor.
// Depends on sbt_pkg and the subcarrier_baseline_tracker RTL.
module subcarrier_baseline_tracker_tb;
  import sbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam longint ENERGY_SAT = (longint'(1) << ESUM_W) - 1;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [SC_W-1:0]  sc;
    logic             fend;
    logic             restart;
  } sample_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] dev;
    logic                    rdy;
    logic [AMP_W-1:0]        energy;
    logic                    ev;
    logic                    done;
    logic                    last;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [AMP_W-1:0]        amplitude = '0;
  logic [SC_W-1:0]         subcarrier = '0;
  logic                    frame_end = 1'b0;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DEV_W-1:0] deviation;
  logic                    is_ready;
  logic [AMP_W-1:0]        motion_energy;
  logic                    energy_valid;
  logic                    calibration_done;
  logic                    frame_last;

  // predictor state and register copies
  logic [SUM_W-1:0]   cal_sum [NUM_SC];
  logic [AMP_W-1:0]   base_tab [NUM_SC];
  logic [FR_W-1:0]    frame_cnt = '0;
  bit                 base_valid = 1'b0;
  longint             energy_acc = 0;
  logic [KLOG_W-1:0]  cfg_klog = CALIB_LOG2_RST;
  logic [ALPHA_W-1:0] cfg_alpha = EMA_ALPHA_RST;
  bit                 cfg_track = 1'b1;

  sample_t pending_samples [$];
  result_t expected_results [$];

  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  bit offered = 1'b0;
  bit taken = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  subcarrier_baseline_tracker u_top (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .amplitude        (amplitude),
    .subcarrier       (subcarrier),
    .frame_end        (frame_end),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .deviation        (deviation),
    .is_ready         (is_ready),
    .motion_energy    (motion_energy),
    .energy_valid     (energy_valid),
    .calibration_done (calibration_done),
    .frame_last       (frame_last)
  );

  always #5 clk = ~clk;

  function automatic result_t track_sample(input sample_t s);
    result_t r;
    longint dev, nb;
    int kk;
    r = '0;
    kk = (cfg_klog > KLOG_MAX) ? KLOG_MAX : int'(cfg_klog);
    if (s.restart) begin
      base_valid = 1'b0;
      frame_cnt = '0;
      energy_acc = 0;
    end
    if (base_valid) begin
      dev = longint'(s.amp) - longint'(base_tab[s.sc]);
      r.dev = dev[DEV_W-1:0];
      r.rdy = 1'b1;
      energy_acc += (dev < 0) ? -dev : dev;
      if (energy_acc > ENERGY_SAT) energy_acc = ENERGY_SAT;
      if (cfg_track) begin
        nb = longint'(base_tab[s.sc]) + ((dev * longint'(cfg_alpha) + 32768) >>> 16);
        if (nb < 0) nb = 0;
        if (nb > longint'(AMP_MAX)) nb = longint'(AMP_MAX);
        base_tab[s.sc] = nb[AMP_W-1:0];
      end
      if (s.fend) begin
        r.energy = AMP_W'(energy_acc / NUM_SC);
        r.ev = 1'b1;
        energy_acc = 0;
      end
    end else begin
      if (frame_cnt == 0) cal_sum[s.sc] = SUM_W'(s.amp);
      else cal_sum[s.sc] = cal_sum[s.sc] + SUM_W'(s.amp);
      if (s.fend) begin
        energy_acc = 0;
        frame_cnt = frame_cnt + 1'b1;
        if (int'(frame_cnt) >= (1 << kk)) begin
          for (int i = 0; i < NUM_SC; i++) base_tab[i] = AMP_W'(cal_sum[i] >> kk);
          base_valid = 1'b1;
          r.done = 1'b1;
        end
      end
    end
    r.last = s.fend;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(track_sample('{amplitude, subcarrier, frame_end, restart}));
        taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = '{deviation, is_ready, motion_energy, energy_valid, calibration_done, frame_last};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual deviation %0d", $time, deviation);
        end else begin
          want = expected_results.pop_front();
          check_field("deviation", 32'(want.dev), 32'(got.dev));
          check_field("is_ready", 32'(want.rdy), 32'(got.rdy));
          check_field("motion_energy", 32'(want.energy), 32'(got.energy));
          check_field("energy_valid", 32'(want.ev), 32'(got.ev));
          check_field("calibration_done", 32'(want.done), 32'(got.done));
          check_field("frame_last", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    sample_t s;
    bit next_valid;
    if (taken) begin
      void'(pending_samples.pop_front());
      taken = 1'b0;
      offered = 1'b0;
    end
    next_valid = offered;
    if (!rst && !offered && pending_samples.size() != 0 &&
        (steady || $urandom_range(99) >= 13)) begin
      s = pending_samples[0];
      amplitude <= s.amp;
      subcarrier <= s.sc;
      frame_end <= s.fend;
      restart <= s.restart;
      offered = 1'b1;
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CALIB_LOG2: cfg_klog = value[KLOG_W-1:0];
      REG_EMA_ALPHA:  cfg_alpha = value[ALPHA_W-1:0];
      REG_TRACK_EN:   cfg_track = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input int klog, input int alpha, input int track);
    wait_drained();
    write_reg(REG_CALIB_LOG2, klog);
    write_reg(REG_EMA_ALPHA, alpha);
    write_reg(REG_TRACK_EN, track);
  endtask

  task automatic push(input int amp, input int sc, input bit fend, input bit rs);
    sample_t s;
    s.amp = AMP_W'(amp);
    s.sc = SC_W'(sc);
    s.fend = fend;
    s.restart = rs;
    pending_samples.push_back(s);
  endtask

  function automatic int near_amp(input int level);
    int v;
    v = level + int'($urandom_range(512)) - 256;
    if (v < 0) v = 0;
    else if (v > int'(AMP_MAX)) v = int'(AMP_MAX);
    return v;
  endfunction

  function automatic int pick_amp(input int level);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return int'(AMP_MAX);
    if (r < 60) return near_amp(level);
    return $urandom_range(int'(AMP_MAX));
  endfunction

  // every subcarrier once, so all sums are written when this opens a calibration
  task automatic full_frame(input int level, input bit rs_first);
    int start;
    start = $urandom_range(NUM_SC - 1);
    for (int i = 0; i < NUM_SC; i++)
      push(near_amp(level), (start + i) % NUM_SC, i == NUM_SC - 1, rs_first && i == 0);
  endtask

  task automatic calibrate(input int level);
    int kk, len;
    kk = (cfg_klog > KLOG_MAX) ? KLOG_MAX : int'(cfg_klog);
    full_frame(level, 1'b1);
    repeat ((1 << kk) - 1) begin
      len = (kk >= 6) ? 1 : $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        push(near_amp(level), $urandom_range(NUM_SC - 1), i == len - 1, 1'b0);
    end
  endtask

  task automatic ready_frames(input int level, input int n);
    int left, len, sc, r;
    left = n;
    sc = 0;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 3 && cfg_klog <= 4) begin
        push(pick_amp(level), $urandom_range(NUM_SC - 1), 1'b0, 1'b1);
        full_frame(level, 1'b0);
        left -= NUM_SC + 1;
      end else if (r < 5 && cfg_klog >= 1 && cfg_klog <= 4) begin
        // one-item frame that restarts, then a proper restart
        push(pick_amp(level), $urandom_range(NUM_SC - 1), 1'b1, 1'b1);
        full_frame(level, 1'b1);
        left -= NUM_SC + 1;
      end else begin
        len = (r < 50) ? NUM_SC : $urandom_range(1, 80);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(99) >= 25) sc = $urandom_range(NUM_SC - 1);
          push(pick_amp(level), sc, j == len - 1, 1'b0);
        end
        left -= len;
      end
    end
  endtask

  initial begin
    int level;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    set_config(0, int'(AMP_MAX), 1);
    for (int i = 0; i < NUM_SC; i++)
      push(i == 0 ? 0 : (i == NUM_SC - 1 ? int'(AMP_MAX) : $urandom_range(int'(AMP_MAX))),
           i, i == NUM_SC - 1, 1'b0);
    push(int'(AMP_MAX), 0, 1'b0, 1'b0);
    push(int'(AMP_MAX), 0, 1'b0, 1'b0);
    push(0, NUM_SC - 1, 1'b0, 1'b0);
    push(0, NUM_SC - 1, 1'b0, 1'b0);
    push($urandom_range(int'(AMP_MAX)), 5, 1'b1, 1'b0);

    level = $urandom_range(int'(AMP_MAX));
    set_config(2, int'(EMA_ALPHA_RST), 0);
    push(pick_amp(level), 7, 1'b1, 1'b1);
    calibrate(level);

    for (int p = 0; p < 4; p++) begin
      level = $urandom_range(int'(AMP_MAX));
      case (p)
        0: begin
          set_config(1, 0, 1);
          hold_req = 1'b1;
        end
        1: set_config(15, $urandom_range(int'(AMP_MAX)), 1);
        2: begin
          set_config(3, $urandom_range(int'(AMP_MAX)), 0);
          level = $urandom_range(2048);
        end
        default: begin
          set_config(2, int'(AMP_MAX), 1);
          steady = 1'b1;
        end
      endcase
      if (p == 1) begin
        // oversized length acts as 1024 frames: keep calibration open
        full_frame(level, 1'b1);
        for (int i = 0; i < 8; i++)
          push(pick_amp(level), $urandom_range(NUM_SC - 1), 1'b1, 1'b0);
      end else begin
        calibrate(level);
        if (p == 2) begin
          // low baselines, no tracking: drive the energy sum into saturation
          for (int i = 0; i < 72; i++)
            push(int'(AMP_MAX) - $urandom_range(63), $urandom_range(NUM_SC - 1), i == 71,
                 1'b0);
        end
        ready_frames(level, 10);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sbt_pkg.sv
rtl/subcarrier_baseline_tracker.sv
tb/subcarrier_baseline_tracker_tb.sv
